// ===== design/ebv_pkg.sv =====
package ebv_pkg;

  localparam int PosW     = 17;
  localparam int SpdW     = 12;
  localparam int CfgIdxW  = 3;

  localparam logic [PosW-1:0] START_POSITION = 17'd5000;
  localparam logic [6:0]      WARN_FACTOR    = 7'd120;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OBSTACLE_POSITION = 3'd0,
    CFG_VEHICLE_LENGTH    = 3'd1,
    CFG_TOP_SPEED         = 3'd2,
    CFG_DRIVE_ACCEL       = 3'd3,
    CFG_BRAKE_DECEL       = 3'd4,
    CFG_COAST_DECEL       = 3'd5,
    CFG_TRIGGER_MARGIN    = 3'd6,
    CFG_MIN_TRIGGER_SPEED = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] obstacle_position;
    logic [16:0] vehicle_length;
    logic [11:0] top_speed;
    logic [7:0]  drive_accel;
    logic [7:0]  brake_decel;
    logic [7:0]  coast_decel;
    logic [15:0] trigger_margin;
    logic [11:0] min_trigger_speed;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [SpdW-1:0] speed;
    logic            brake_latch;
    logic            auto_drive;
  } state_t;

  typedef struct packed {
    logic toggle_auto;
    logic restart;
    logic drive_request;
  } cmd_t;

  typedef struct packed {
    logic [PosW-1:0] position;
    logic [SpdW-1:0] speed;
    logic [PosW-1:0] gap;
    logic            brake_active;
    logic            auto_mode;
    logic            collision_warning;
  } res_t;

endpackage

// ===== design/ebv_in_if.sv =====
interface ebv_in_if;
  logic valid;
  logic ready;
  logic toggle_auto;
  logic restart;
  logic drive_request;

  modport source (output valid, output toggle_auto, output restart, output drive_request,
                  input ready);
  modport sink (input valid, input toggle_auto, input restart, input drive_request,
                output ready);
endinterface

// ===== design/ebv_out_if.sv =====
interface ebv_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] position;
  logic [11:0] speed;
  logic [16:0] gap;
  logic        brake_active;
  logic        auto_mode;
  logic        collision_warning;

  modport source (output valid, output position, output speed, output gap,
                  output brake_active, output auto_mode, output collision_warning,
                  input ready);
  modport sink (input valid, input position, input speed, input gap,
                input brake_active, input auto_mode, input collision_warning,
                output ready);
endinterface

// ===== design/ebv_cfg_if.sv =====
interface ebv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/ebv_step.sv =====
module ebv_step (
  input  ebv_pkg::cfg_t   cfg,
  input  ebv_pkg::state_t st,
  input  ebv_pkg::cmd_t   cmd,
  output ebv_pkg::state_t nst,
  output ebv_pkg::res_t   res
);
  import ebv_pkg::*;

  logic [16:0]        pos0;
  logic [11:0]        spd0;
  logic               latch0;
  logic               auto0;
  logic [17:0]        front;
  logic [18:0]        gap_full;
  logic [16:0]        gap;
  logic [18:0]        warn_lim;
  logic               over_margin;
  logic [16:0]        excess;
  logic [25:0]        lhs;
  logic [23:0]        sq;
  logic               trig;
  logic               brake;
  logic               go;
  logic signed [13:0] s_raw;
  logic [11:0]        spd1;
  logic [17:0]        pos_sum;
  logic               reach;
  logic [16:0]        stop_pos;

  always_comb begin
    // Toggle first, then restart overrides everything.
    pos0   = cmd.restart ? START_POSITION : st.position;
    spd0   = cmd.restart ? 12'd0 : st.speed;
    latch0 = cmd.restart ? 1'b0 : st.brake_latch;
    auto0  = cmd.restart ? 1'b0 : (st.auto_drive ^ cmd.toggle_auto);

    front    = {1'b0, pos0} + {1'b0, cfg.vehicle_length};
    gap_full = {2'b0, cfg.obstacle_position} - {1'b0, front};
    gap      = gap_full[18] ? 17'd0 : gap_full[16:0];

    warn_lim = 19'(spd0) * 19'(WARN_FACTOR);

    // Below the margin the left side is negative and the test always passes.
    over_margin = gap > {1'b0, cfg.trigger_margin};
    excess      = gap - {1'b0, cfg.trigger_margin};
    lhs         = 26'({cfg.brake_decel, 1'b0}) * 26'(excess);
    sq          = 24'(spd0) * 24'(spd0);
    trig = (gap != 17'd0) && (!over_margin || (lhs <= 26'(sq)))
           && (spd0 > cfg.min_trigger_speed);

    brake = latch0 || trig;
    go    = (auto0 && !trig) || cmd.drive_request;

    priority if (brake) begin
      s_raw = $signed(14'(spd0)) - $signed(14'(cfg.brake_decel));
    end else if (go) begin
      s_raw = $signed(14'(spd0)) + $signed(14'(cfg.drive_accel));
    end else begin
      s_raw = $signed(14'(spd0)) - $signed(14'(cfg.coast_decel));
    end

    // The ceiling applies only outside braking.
    priority if (s_raw[13]) begin
      spd1 = 12'd0;
    end else if (!brake && (s_raw[12:0] > {1'b0, cfg.top_speed})) begin
      spd1 = cfg.top_speed;
    end else begin
      spd1 = s_raw[11:0];
    end

    pos_sum  = {1'b0, pos0} + 18'(spd1);
    reach    = ({1'b0, pos_sum} + {2'b0, cfg.vehicle_length})
               >= {2'b0, cfg.obstacle_position};
    stop_pos = (cfg.obstacle_position < cfg.vehicle_length) ? 17'd0
               : (cfg.obstacle_position - cfg.vehicle_length);

    nst.position    = reach ? stop_pos : pos_sum[16:0];
    nst.speed       = reach ? 12'd0 : spd1;
    nst.brake_latch = brake;
    nst.auto_drive  = auto0 && !trig;

    res.position          = nst.position;
    res.speed             = nst.speed;
    res.gap               = gap;
    res.brake_active      = brake;
    res.auto_mode         = nst.auto_drive;
    res.collision_warning = {2'b0, gap} < warn_lim;
  end

endmodule

// ===== design/emergency_brake_vehicle_step_core.sv =====
// A word accepted on in_ch waits in the input register; its tick result enters the
// result register once that register is free or draining, for out_ch to hand over.
// Throughput: one word per cycle unless out_ch stalls; the tick update sits
// combinationally between input and result registers; its state feeds the next word.
// Reset (rst_n low, synchronous): vehicle at position 5000, speed 0, brake and
// auto-drive off, all configuration registers at their defaults, both stages empty.
module emergency_brake_vehicle_step_core (
  input logic clk,
  input logic rst_n,
  ebv_in_if.sink    in_ch,
  ebv_out_if.source out_ch,
  ebv_cfg_if.sink   cfg_ch
);
  import ebv_pkg::*;

  cfg_t   cfg_r;
  cfg_t   cfg_nxt;
  state_t st_r;
  state_t st_nxt;
  state_t st_calc;
  cmd_t   cmd_r;
  res_t   res_r;
  res_t   res_calc;
  logic   s1_v_r;
  logic   out_v_r;
  logic   s1_fire;
  logic   in_fire;

  ebv_step u_step (
    .cfg (cfg_r),
    .st  (st_r),
    .cmd (cmd_r),
    .nst (st_calc),
    .res (res_calc)
  );

  // The held word moves on whenever the result register is free or draining.
  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_v_r;
  assign out_ch.position          = res_r.position;
  assign out_ch.speed             = res_r.speed;
  assign out_ch.gap               = res_r.gap;
  assign out_ch.brake_active      = res_r.brake_active;
  assign out_ch.auto_mode         = res_r.auto_mode;
  assign out_ch.collision_warning = res_r.collision_warning;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_OBSTACLE_POSITION: cfg_nxt.obstacle_position = cfg_ch.data;
        CFG_VEHICLE_LENGTH:    cfg_nxt.vehicle_length    = cfg_ch.data;
        CFG_TOP_SPEED:         cfg_nxt.top_speed         = cfg_ch.data[11:0];
        CFG_DRIVE_ACCEL:       cfg_nxt.drive_accel       = cfg_ch.data[7:0];
        CFG_BRAKE_DECEL:       cfg_nxt.brake_decel       = cfg_ch.data[7:0];
        CFG_COAST_DECEL:       cfg_nxt.coast_decel       = cfg_ch.data[7:0];
        CFG_TRIGGER_MARGIN:    cfg_nxt.trigger_margin    = cfg_ch.data[15:0];
        CFG_MIN_TRIGGER_SPEED: cfg_nxt.min_trigger_speed = cfg_ch.data[11:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
    st_nxt = s1_fire ? st_calc : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obstacle_position <= 17'd65000;
      cfg_r.vehicle_length    <= 17'd6000;
      cfg_r.top_speed         <= 12'd1200;
      cfg_r.drive_accel       <= 8'd15;
      cfg_r.brake_decel       <= 8'd40;
      cfg_r.coast_decel       <= 8'd5;
      cfg_r.trigger_margin    <= 16'd2000;
      cfg_r.min_trigger_speed <= 12'd50;
      st_r.position           <= START_POSITION;
      st_r.speed              <= 12'd0;
      st_r.brake_latch        <= 1'b0;
      st_r.auto_drive         <= 1'b0;
      s1_v_r                  <= 1'b0;
      out_v_r                 <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      st_r  <= st_nxt;
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r.toggle_auto   <= in_ch.toggle_auto;
      cmd_r.restart       <= in_ch.restart;
      cmd_r.drive_request <= in_ch.drive_request;
    end
    if (s1_fire) begin
      res_r <= res_calc;
    end
  end

endmodule
